// File: hdl/quad_triangle_strip_normals_unit_assert.svh
// Assertion macros shared by the quad strip normals block.
// Include-guarded; no other dependencies.
`ifndef QUAD_TRIANGLE_STRIP_NORMALS_UNIT_ASSERT_SVH
`define QUAD_TRIANGLE_STRIP_NORMALS_UNIT_ASSERT_SVH
// Implication checked on every edge outside reset.
`define QTSN_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication outside reset.
`define QTSN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hdl/qtsn_pkg.sv
// Package for the quad strip normals block: widths, types, command struct.
// No dependencies.
`timescale 1ns / 1ps
package qtsn_pkg;
  localparam int CoordW = 32;
  localparam int NormW  = 16;
  localparam int IdxW   = 32;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t c0;
    vec_t c1;
    vec_t c2;
    vec_t c3;
  } quad_t;

  typedef struct packed {
    logic signed [CoordW-1:0] vert_x;
    logic signed [CoordW-1:0] vert_y;
    logic signed [CoordW-1:0] vert_z;
    logic signed [NormW-1:0]  norm_x;
    logic signed [NormW-1:0]  norm_y;
    logic signed [NormW-1:0]  norm_z;
    logic [IdxW-1:0]          vert_index;
    logic                     last_vertex;
  } vert_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;   // capture quad
    logic       start;  // begin normal of triangle tri
    logic       tri_sel;
    logic       emit;   // load output register
    logic [1:0] vsel;   // vertex within triangle
    logic       last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic done;
  } sts_t;
endpackage

// File: hdl/qtsn_if.sv
// Valid/ready stream interface carrying a generic payload.
// Depends on nothing; payload type is a parameter.
`timescale 1ns / 1ps
interface qtsn_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: hdl/qtsn_norm.sv
// Sequential face normal unit: edges, cross, scale, sqrt, three divides.
// Depends on qtsn_pkg.
`timescale 1ns / 1ps
module qtsn_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  qtsn_pkg::vec_t     a_i,
  input  qtsn_pkg::vec_t     b_i,
  input  qtsn_pkg::vec_t     c_i,
  output logic               done_o,
  output logic signed [15:0] nx_o,
  output logic signed [15:0] ny_o,
  output logic signed [15:0] nz_o
);
  import qtsn_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0, S_EDGE = 4'd1, S_MUL = 4'd2, S_CRS = 4'd3,
    S_SHR = 4'd4, S_SHL = 4'd5, S_SQ = 4'd6, S_SQRT = 4'd7, S_DIV = 4'd8, S_DONE = 4'd9;

  logic [3:0] st_q, st_d;
  logic signed [32:0] e_q [3], f_q [3];
  logic signed [63:0] p_q [6];
  logic [62:0] m_q [3];
  logic [2:0]  neg_q;
  logic [63:0] s_q, res_q, bit_q;
  logic [5:0]  cnt_q;
  logic [1:0]  k_q;
  logic [46:0] rem_q;
  logic [45:0] quo_q;
  logic [14:0] n_q [3];

  function automatic logic signed [32:0] fit(input logic signed [32:0] v, input logic sh);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : v;
    if (sh) m = m >> 1;
    return v[32] ? 33'(-$signed(m)) : $signed(m);
  endfunction

  logic signed [32:0] de [3], df [3];
  logic sh_e, sh_f;
  always_comb begin
    de[0] = 33'(b_i.x) - 33'(a_i.x); df[0] = 33'(c_i.x) - 33'(a_i.x);
    de[1] = 33'(b_i.y) - 33'(a_i.y); df[1] = 33'(c_i.y) - 33'(a_i.y);
    de[2] = 33'(b_i.z) - 33'(a_i.z); df[2] = 33'(c_i.z) - 33'(a_i.z);
    sh_e = 1'b0; sh_f = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if (de[k] > 33'sh07FFFFFFF || de[k] < -33'sh07FFFFFFF) sh_e = 1'b1;
      if (df[k] > 33'sh07FFFFFFF || df[k] < -33'sh07FFFFFFF) sh_f = 1'b1;
    end
  end

  logic [62:0] mx;
  logic [63:0] sum_b;
  logic [46:0] rem_sh;
  logic signed [63:0] crs [3];
  always_comb begin
    mx = m_q[0];
    if (m_q[1] > mx) mx = m_q[1];
    if (m_q[2] > mx) mx = m_q[2];
    sum_b = res_q + bit_q;
    rem_sh = {rem_q[45:0], quo_q[45]};
    for (int k = 0; k < 3; k++) crs[k] = p_q[2*k] - p_q[2*k+1];
  end

  always_comb begin
    st_d = st_q;
    case (st_q)
      S_IDLE: if (start_i) st_d = S_EDGE;
      S_EDGE: st_d = S_MUL;
      S_MUL:  st_d = S_CRS;
      S_CRS:  st_d = S_SHR;
      S_SHR:  if (mx == '0) st_d = S_DONE;
              else if (mx < 63'(1) << 30) st_d = S_SHL;
              else if (mx < 63'(1) << 31) st_d = S_SQ;
      S_SHL:  if (mx >= 63'(1) << 29) st_d = S_SQ;
      S_SQ:   st_d = S_SQRT;
      S_SQRT: if (bit_q == '0) st_d = S_DIV;
      S_DIV:  if (k_q == 2'd2 && cnt_q == 6'd46) st_d = S_DONE;
      S_DONE: st_d = S_IDLE;
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_q <= S_IDLE;
    else st_q <= st_d;
  end

  // corners are taken the cycle after start, once the quad register is loaded
  always_ff @(posedge clk_i) begin
    case (st_q)
      S_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e_q[k] <= fit(de[k], sh_e);
          f_q[k] <= fit(df[k], sh_f);
          n_q[k] <= '0;
        end
      end
      S_MUL: begin
        p_q[0] <= e_q[1] * f_q[2]; p_q[1] <= e_q[2] * f_q[1];
        p_q[2] <= e_q[2] * f_q[0]; p_q[3] <= e_q[0] * f_q[2];
        p_q[4] <= e_q[0] * f_q[1]; p_q[5] <= e_q[1] * f_q[0];
      end
      S_CRS: begin
        for (int k = 0; k < 3; k++) begin
          neg_q[k] <= crs[k][63];
          m_q[k]   <= crs[k][63] ? 63'(-crs[k]) : 63'(crs[k]);
        end
      end
      S_SHR: if (mx >= 63'(1) << 30) for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
      S_SHL: if (mx < 63'(1) << 29) for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] << 1;
      S_SQ: begin
        s_q <= 64'(m_q[0][29:0]) * 64'(m_q[0][29:0]) + 64'(m_q[1][29:0]) * 64'(m_q[1][29:0])
             + 64'(m_q[2][29:0]) * 64'(m_q[2][29:0]);
        res_q <= '0;
        bit_q <= 64'(1) << 62;
      end
      S_SQRT: begin
        if (bit_q != '0) begin
          if (s_q >= sum_b) begin
            s_q <= s_q - sum_b;
            res_q <= (res_q >> 1) + bit_q;
          end else res_q <= res_q >> 1;
          bit_q <= bit_q >> 2;
        end
        k_q <= '0; cnt_q <= '0; rem_q <= '0;
        quo_q <= {m_q[0][29:0], 14'd0} + 46'(res_q[31:1]);
      end
      S_DIV: begin
        if (rem_sh >= 47'(res_q)) begin
          rem_q <= rem_sh - 47'(res_q);
          quo_q <= {quo_q[44:0], 1'b1};
        end else begin
          rem_q <= rem_sh;
          quo_q <= {quo_q[44:0], 1'b0};
        end
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd45) begin
          n_q[k_q] <= (rem_sh >= 47'(res_q)) ? {quo_q[13:0], 1'b1} : {quo_q[13:0], 1'b0};
        end
        if (cnt_q == 6'd46) begin
          cnt_q <= '0; rem_q <= '0;
          k_q <= k_q + 2'd1;
          quo_q <= {m_q[(k_q == 2'd0) ? 1 : 2][29:0], 14'd0} + 46'(res_q[31:1]);
        end
      end
      default: ;
    endcase
  end

  assign done_o = (st_q == S_DONE);
  assign nx_o = neg_q[0] ? -$signed({1'b0, n_q[0]}) : $signed({1'b0, n_q[0]});
  assign ny_o = neg_q[1] ? -$signed({1'b0, n_q[1]}) : $signed({1'b0, n_q[1]});
  assign nz_o = neg_q[2] ? -$signed({1'b0, n_q[2]}) : $signed({1'b0, n_q[2]});
endmodule

// File: hdl/qtsn_dp.sv
// Datapath: quad register, normal unit, output register and index counter.
// Depends on qtsn_pkg, qtsn_norm.
`timescale 1ns / 1ps
module qtsn_dp (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  qtsn_pkg::quad_t quad_i,
  input  qtsn_pkg::cmd_t  cmd_i,
  output qtsn_pkg::sts_t  sts_o,
  output qtsn_pkg::vert_t vert_o
);
  import qtsn_pkg::*;

  quad_t quad_q;
  vert_t vert_q;
  logic [IdxW-1:0] idx_q;
  vec_t ta, tb, tc, vsrc;
  logic signed [NormW-1:0] nx, ny, nz;

  always_comb begin
    ta = cmd_i.tri_sel ? quad_q.c1 : quad_q.c0;
    tb = cmd_i.tri_sel ? quad_q.c2 : quad_q.c1;
    tc = cmd_i.tri_sel ? quad_q.c3 : quad_q.c2;
    case (cmd_i.vsel)
      2'd0: vsrc = ta;
      2'd1: vsrc = tb;
      default: vsrc = tc;
    endcase
  end

  qtsn_norm u_norm (
    .clk_i, .rst_ni, .start_i(cmd_i.start), .a_i(ta), .b_i(tb), .c_i(tc),
    .done_o(sts_o.done), .nx_o(nx), .ny_o(ny), .nz_o(nz)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) quad_q <= quad_i;
    if (cmd_i.emit) begin
      vert_q <= '{vert_x: vsrc.x, vert_y: vsrc.y, vert_z: vsrc.z, norm_x: nx, norm_y: ny,
                  norm_z: nz, vert_index: idx_q, last_vertex: cmd_i.last};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else if (cmd_i.emit) idx_q <= idx_q + 32'd1;
  end

  assign vert_o = vert_q;
endmodule

// File: hdl/qtsn_ctrl.sv
// Controller: sequences load, two normals and six vertex transfers.
// Depends on qtsn_pkg and the assertion header.
`timescale 1ns / 1ps
module qtsn_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  qtsn_pkg::sts_t sts_i,
  output qtsn_pkg::cmd_t cmd_o
);
  import qtsn_pkg::*;
`include "quad_triangle_strip_normals_unit_assert.svh"

  localparam logic [1:0] C_IDLE = 2'd0, C_NORM = 2'd1, C_EMIT = 2'd2;
  logic [1:0] st_q, st_d;
  logic tri_q, tri_d, ov_q, ov_d, go;
  logic [1:0] v_q, v_d;

  assign in_ready_o = (st_q == C_IDLE);
  assign out_valid_o = ov_q;
  assign go = (st_q == C_EMIT) && (!ov_q || out_ready_i);

  always_comb begin
    st_d = st_q; tri_d = tri_q; v_d = v_q;
    ov_d = ov_q && !out_ready_i;
    cmd_o = '0;
    cmd_o.tri_sel = tri_q;
    cmd_o.vsel = v_q;
    case (st_q)
      C_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1; st_d = C_NORM; tri_d = 1'b0; v_d = '0;
      end
      C_NORM: begin
        if (sts_i.done) st_d = C_EMIT;
      end
      C_EMIT: if (go) begin
        cmd_o.emit = 1'b1; ov_d = 1'b1;
        cmd_o.last = tri_q && v_q == 2'd2;
        if (v_q == 2'd2) begin
          v_d = '0; tri_d = 1'b1;
          st_d = tri_q ? C_IDLE : C_NORM;
        end else v_d = v_q + 2'd1;
      end
      default: st_d = C_IDLE;
    endcase
    cmd_o.start = (st_q == C_IDLE && in_valid_i) || (go && v_q == 2'd2 && !tri_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= C_IDLE; tri_q <= 1'b0; v_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; tri_q <= tri_d; v_q <= v_d; ov_q <= ov_d;
    end
  end

  `QTSN_ASSERT(a_emit_only_free, cmd_o.emit, !ov_q || out_ready_i)
  `QTSN_ASSERT(a_vsel_range, st_q == C_EMIT, v_q != 2'd3)
  `QTSN_ASSERT_NEXT(a_load_starts, cmd_o.load, st_q == C_NORM && !tri_q)
endmodule

// File: hdl/quad_triangle_strip_normals_unit.sv
// Quad to triangle strip with flat Q1.14 face normals, six vertex transfers per quad.
// From quad transfer to first vertex: edges, cross product, shift normalize, sqrt,
// then three serial divides; a degenerate face skips the sqrt and the divides.
// The two normals run in series, and a new quad is accepted only after all six emits.
// Async active-low reset clears control and the vertex index; payload is not reset.
// Depends on qtsn_pkg, qtsn_if, qtsn_ctrl, qtsn_dp.
`timescale 1ns / 1ps
module quad_triangle_strip_normals_unit (
  input  logic clk_i,
  input  logic rst_ni,
  qtsn_if.sink   in_if,
  qtsn_if.source out_if
);
  import qtsn_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller owns the handshakes; the datapath never sees them
  qtsn_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  qtsn_dp u_dp (
    .clk_i, .rst_ni, .quad_i(in_if.data), .cmd_i(cmd), .sts_o(sts), .vert_o(out_if.data)
  );
endmodule
